### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the glob matcher.
// Each macro checks one implication on the rising edge of clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GWM_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define GWM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Constants, widths and inter-module types of the glob matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gwm_pkg;

  // Pattern storage depth and derived widths.
  localparam int PatLen = 64;
  localparam int AddrW  = $clog2(PatLen);
  localparam int PosW   = $clog2(PatLen + 1);

  // Pattern syntax bytes.
  localparam logic [7:0] ChBang  = 8'h21;  // '!'
  localparam logic [7:0] ChBsl   = 8'h5C;  // backslash
  localparam logic [7:0] ChStar  = 8'h2A;  // '*'
  localparam logic [7:0] ChQmark = 8'h3F;  // '?'
  localparam logic [7:0] ChLbr   = 8'h5B;  // '['
  localparam logic [7:0] ChRbr   = 8'h5D;  // ']'
  localparam logic [7:0] ChDash  = 8'h2D;  // '-'

  // Request kinds carried in in_tuser.
  localparam logic ReqPattern = 1'b0;
  localparam logic ReqName    = 1'b1;

  // Command from the controller to the scan unit.
  typedef struct packed {
    logic       start;  // begin a pass over the stored pattern
    logic       cons;   // 1: consume a name byte, 0: restart the live set
    logic [7:0] ch;     // name byte to consume
  } scan_cmd_t;

  // Status from the scan unit to the controller.
  typedef struct packed {
    logic done;     // pass finished, live set updated this edge
    logic end_hit;  // live set accepts end of name
  } scan_stat_t;

endpackage

### rtl/gwm_store.sv
// ----------------------------------------------------------------------------
// gwm_store
// Pattern byte memory: one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwm_store (
  input  logic                     clk,
  input  logic                     we,
  input  logic [gwm_pkg::AddrW-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [gwm_pkg::AddrW-1:0] raddr,
  output logic [7:0]               rdata_r
);
  import gwm_pkg::*;

  logic [7:0] mem [PatLen];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### rtl/gwm_scan.sv
// ----------------------------------------------------------------------------
// gwm_scan
// Walks the stored pattern one byte per cycle, parses it into tokens and
// builds the next live position set from the current one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwm_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gwm_pkg::scan_cmd_t        cmd,
  input  logic [gwm_pkg::PosW-1:0]  count,
  input  logic                      last_bsl,
  output logic                      re,
  output logic [gwm_pkg::AddrW-1:0] raddr,
  input  logic [7:0]                rdata,
  output gwm_pkg::scan_stat_t       stat
);
  import gwm_pkg::*;

  typedef enum logic [2:0] {
    P_TOK, P_BSL, P_CLS0, P_CLS, P_RNG
  } pstate_t;

  pstate_t         ps_r, ps_nxt;
  logic            run_r, dv_r, cons_r;
  logic [7:0]      ch_r;
  logic [PosW-1:0] rd_pos_r, dpos_r;
  logic [PatLen:0] live_r, nxt_r, nxt_nxt, fin;
  logic            act_r, act_nxt, inv_r, inv_nxt, hit_r, hit_nxt;
  logic            pok_r, pok_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic            lv, a, cls_go, finish;
  logic [PosW-1:0] q1, cm1;

  // Read address generation.
  assign re    = run_r && (rd_pos_r < count);
  assign raddr = rd_pos_r[AddrW-1:0];

  // Pass ends once every byte has been read and parsed.
  assign finish = run_r && !dv_r && (rd_pos_r == count);

  // Token parser on the returning byte stream.
  always_comb begin
    nxt_nxt  = nxt_r;
    ps_nxt   = ps_r;
    act_nxt  = act_r;
    inv_nxt  = inv_r;
    hit_nxt  = hit_r;
    pok_nxt  = pok_r;
    prev_nxt = prev_r;
    q1       = dpos_r + PosW'(1);
    lv       = live_r[dpos_r];
    a        = cons_r && lv;
    cls_go   = 1'b0;
    if (run_r && dv_r) begin
      case (ps_r)
        P_TOK: begin
          case (rdata)
            ChStar: begin
              if (a) nxt_nxt[dpos_r] = 1'b1;
              if (nxt_nxt[dpos_r]) nxt_nxt[q1] = 1'b1;
            end
            ChQmark: begin
              if (a) nxt_nxt[q1] = 1'b1;
            end
            ChBsl: begin
              act_nxt = a;
              ps_nxt  = P_BSL;
            end
            ChLbr: begin
              act_nxt = a;
              inv_nxt = 1'b0;
              hit_nxt = 1'b0;
              pok_nxt = 1'b0;
              ps_nxt  = P_CLS0;
            end
            default: begin
              if (a && rdata == ch_r) nxt_nxt[q1] = 1'b1;
            end
          endcase
        end
        P_BSL: begin
          if (act_r && rdata == ch_r) nxt_nxt[q1] = 1'b1;
          ps_nxt = P_TOK;
        end
        P_CLS0: begin
          if (rdata == ChBang) begin
            inv_nxt = 1'b1;
            ps_nxt  = P_CLS;
          end else begin
            cls_go = 1'b1;
          end
        end
        P_CLS: begin
          cls_go = 1'b1;
        end
        P_RNG: begin
          if (pok_r && ch_r >= prev_r && ch_r <= rdata) hit_nxt = 1'b1;
          prev_nxt = rdata;
          pok_nxt  = 1'b1;
          ps_nxt   = P_CLS;
        end
        default: ps_nxt = P_TOK;
      endcase
      // Class body byte.
      if (cls_go) begin
        if (rdata == ChRbr) begin
          if (act_r && (hit_r != inv_r)) nxt_nxt[q1] = 1'b1;
          ps_nxt = P_TOK;
        end else if (rdata == ChDash) begin
          ps_nxt = P_RNG;
        end else begin
          if (rdata == ch_r) hit_nxt = 1'b1;
          prev_nxt = rdata;
          pok_nxt  = 1'b1;
        end
      end
    end
  end

  // A class left open at pattern end closes there.
  always_comb begin
    fin = nxt_r;
    if ((ps_r == P_CLS0 || ps_r == P_CLS || ps_r == P_RNG)
        && act_r && (hit_r != inv_r)) begin
      fin[count] = 1'b1;
    end
  end

  // End of name is accepted at the pattern end or on a trailing backslash.
  assign cm1            = count - PosW'(1);
  assign stat.done      = finish;
  assign stat.end_hit   = live_r[count] || (last_bsl && count != '0 && live_r[cm1]);

  // Pass control, parser state and live set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      dv_r   <= 1'b0;
      ps_r   <= P_TOK;
      live_r <= (PatLen + 1)'(1);
    end else begin
      dv_r   <= re;
      dpos_r <= rd_pos_r;
      if (re) rd_pos_r <= rd_pos_r + PosW'(1);
      ps_r   <= ps_nxt;
      act_r  <= act_nxt;
      inv_r  <= inv_nxt;
      hit_r  <= hit_nxt;
      pok_r  <= pok_nxt;
      prev_r <= prev_nxt;
      nxt_r  <= nxt_nxt;
      if (finish) begin
        live_r <= fin;
        run_r  <= 1'b0;
      end
      if (cmd.start) begin
        run_r    <= 1'b1;
        rd_pos_r <= '0;
        dv_r     <= 1'b0;
        ps_r     <= P_TOK;
        act_r    <= 1'b0;
        cons_r   <= cmd.cons;
        ch_r     <= cmd.ch;
        nxt_r    <= cmd.cons ? '0 : (PatLen + 1)'(1);
      end
    end
  end

endmodule

### rtl/wildcard_glob_matcher_unit.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit
// Loads a glob pattern and matches names against it byte by byte.
// ----------------------------------------------------------------------------
// A pattern word is stored as it is taken. A pattern terminator and a name
// byte each run one pass over the stored pattern (two passes when a name
// byte ends loading), and a name terminator runs a restart pass once the
// output is free (after one more pass when it ends loading). The stored
// pattern holds 0 to 64 bytes. The pattern memory's single read port
// delivers one pattern byte per cycle to the token parser.
// The result word goes to an output register, so a new input word is
// taken while a result still waits.
`timescale 1ns / 1ps

module wildcard_glob_matcher_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic       in_tuser,   // [0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] pattern_overflow, rest zero
);
  import gwm_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [1:0] {C_IDLE, C_SCAN, C_END} cstate_t;
  typedef enum logic [1:0] {F_NONE, F_CONS, F_END} follow_t;

  cstate_t         cs_r;
  follow_t         fol_r;
  logic [PosW-1:0] cnt_r, ld_cnt;
  logic            ovf_r, loading_r, last_bsl_r;
  logic [7:0]      ch_r;
  logic            omatch_r, oovf_r, ovalid_r;
  logic            acc, we, re, out_free;
  logic [AddrW-1:0] raddr;
  logic [7:0]      rdata;
  scan_cmd_t       cmd;
  scan_stat_t      stat;

  assign in_tready  = (cs_r == C_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, oovf_r, omatch_r};
  assign out_free   = !ovalid_r || out_tready;
  assign ld_cnt     = loading_r ? cnt_r : '0;
  assign we         = acc && in_tuser == ReqPattern && in_tdata != '0 && ld_cnt < PatLen;

  // Scan commands issued by the controller.
  always_comb begin
    cmd = '{start: 1'b0, cons: 1'b0, ch: ch_r};
    case (cs_r)
      C_IDLE: begin
        if (acc) begin
          if (in_tuser == ReqPattern) begin
            cmd.start = (in_tdata == '0);
          end else if (loading_r) begin
            cmd.start = 1'b1;
          end else if (in_tdata != '0) begin
            cmd.start = 1'b1;
            cmd.cons  = 1'b1;
            cmd.ch    = in_tdata;
          end
        end
      end
      C_SCAN: begin
        if (stat.done && fol_r == F_CONS) begin
          cmd.start = 1'b1;
          cmd.cons  = 1'b1;
        end
      end
      C_END: begin
        cmd.start = out_free;
      end
      default: cmd.start = 1'b0;
    endcase
  end

  gwm_store u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (ld_cnt[AddrW-1:0]),
    .wdata   (in_tdata),
    .re      (re),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  gwm_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .count    (cnt_r),
    .last_bsl (last_bsl_r),
    .re       (re),
    .raddr    (raddr),
    .rdata    (rdata),
    .stat     (stat)
  );

  // Controller state, pattern bookkeeping and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r       <= C_IDLE;
      fol_r      <= F_NONE;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      loading_r  <= 1'b1;
      last_bsl_r <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (cs_r)
        C_IDLE: begin
          if (acc) begin
            ch_r <= in_tdata;
            if (in_tuser == ReqPattern) begin
              if (!loading_r) begin
                loading_r <= 1'b1;
                ovf_r     <= 1'b0;
                cnt_r     <= '0;
              end
              if (in_tdata == '0) begin
                loading_r <= 1'b0;
                fol_r     <= F_NONE;
                cs_r      <= C_SCAN;
              end else if (ld_cnt < PatLen) begin
                cnt_r      <= ld_cnt + PosW'(1);
                last_bsl_r <= (in_tdata == ChBsl);
              end else begin
                ovf_r <= 1'b1;
              end
            end else if (loading_r) begin
              loading_r <= 1'b0;
              fol_r     <= (in_tdata != '0) ? F_CONS : F_END;
              cs_r      <= C_SCAN;
            end else if (in_tdata != '0) begin
              fol_r <= F_NONE;
              cs_r  <= C_SCAN;
            end else begin
              cs_r <= C_END;
            end
          end
        end
        C_SCAN: begin
          if (stat.done) begin
            case (fol_r)
              F_CONS:  fol_r <= F_NONE;
              F_END:   cs_r  <= C_END;
              default: cs_r  <= C_IDLE;
            endcase
          end
        end
        C_END: begin
          if (out_free) begin
            ovalid_r <= 1'b1;
            omatch_r <= stat.end_hit;
            oovf_r   <= ovf_r;
            fol_r    <= F_NONE;
            cs_r     <= C_SCAN;
          end
        end
        default: cs_r <= C_IDLE;
      endcase
    end
  end

  // Checks on the controller and scan unit.
  `GWM_ASSERT_NOW(a_done_in_scan, stat.done, cs_r == C_SCAN, "scan finished outside a pass")
  `GWM_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= PatLen, "pattern count beyond storage")
  `GWM_ASSERT_NEXT(a_name_starts_scan, acc && in_tuser == ReqName && in_tdata != '0,
                   cs_r == C_SCAN, "name word did not start a pass")
  `GWM_ASSERT_NOW(a_no_start_busy, cmd.start && cs_r == C_SCAN, stat.done,
                  "pass started while another runs")

endmodule
